@@ rtl/avc_cfg_pkg.sv @@
// Package for the AVC decoder configuration record parser.
// Holds the byte role and status codes and the request and result payload types.
// No dependencies.
`timescale 1ns / 1ps

package avc_cfg_pkg;

  // Byte roles, which double as the phase codes of the parser.
  localparam logic [2:0] RoleHeader  = 3'd0;
  localparam logic [2:0] RoleSpsLen  = 3'd1;
  localparam logic [2:0] RoleSpsData = 3'd2;
  localparam logic [2:0] RolePpsCnt  = 3'd3;
  localparam logic [2:0] RolePpsLen  = 3'd4;
  localparam logic [2:0] RolePpsData = 3'd5;
  localparam logic [2:0] RoleTrail   = 3'd6;
  localparam logic [2:0] RoleError   = 3'd7;

  localparam logic [1:0] StRunning = 2'd0;
  localparam logic [1:0] StOk      = 2'd1;
  localparam logic [1:0] StBadVer  = 2'd2;
  localparam logic [1:0] StTrunc   = 2'd3;

  localparam logic [7:0] VersionOne = 8'd1;
  localparam logic [4:0] SpsMask    = 5'd31;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [1:0]  status;
    logic [7:0]  profile_code;
    logic [7:0]  compat_flags;
    logic [7:0]  level_code;
    logic [2:0]  nal_length_bytes;
    logic [4:0]  sps_total;
    logic [7:0]  pps_total;
    logic [7:0]  set_index;
    logic [15:0] set_length;
    logic        end_of_box;
  } out_item_t;

endpackage

@@ rtl/avc_config_record_parser.sv @@
// AVC decoder configuration record parser, top level.
// Depends on avc_cfg_pkg for the codes and payload types.
`timescale 1ns / 1ps

// Takes one payload byte of an AVC decoder configuration box per request and
// returns one result per byte: its role in the record, the captured header
// fields, the current parameter set index and length, and a status that shows
// a bad version from the version byte on and, on the final byte, whether the
// record was accepted or truncated. The parse state is updated by a single
// combinational step between the input and the result register, so one byte
// is accepted every cycle while no result waits uncollected, and a new byte is
// taken in the same cycle that a waiting result is collected. After the final
// byte all state returns to its reset value, ready for the next box.
module avc_config_record_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  avc_cfg_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output avc_cfg_pkg::out_item_t out_data_o
);
  import avc_cfg_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [7:0]  sets_left_q, sets_left_d;
  logic [7:0]  set_counter_q, set_counter_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [15:0] cur_len_q, cur_len_d;
  logic [7:0]  profile_q, profile_d;
  logic [7:0]  compat_q, compat_d;
  logic [7:0]  level_q, level_d;
  logic [1:0]  nal_q, nal_d;
  logic [4:0]  sps_total_q, sps_total_d;
  logic [7:0]  pps_count_q, pps_count_d;
  logic [1:0]  err_q, err_d;

  logic        out_valid_q;
  out_item_t   out_q, out_d;

  logic        in_acc;
  logic        finish;
  logic        is_sps;
  logic [7:0]  b;
  logic [15:0] len_word;
  logic [7:0]  idx;
  logic [15:0] len;
  logic [1:0]  status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign len_word   = {length_high_q, b};
  assign is_sps     = (phase_q == RoleSpsLen) || (phase_q == RoleSpsData);

  always_comb begin
    phase_d       = phase_q;
    hpos_d        = hpos_q;
    sets_left_d   = sets_left_q;
    set_counter_d = set_counter_q;
    bytes_left_d  = bytes_left_q;
    length_high_d = length_high_q;
    cur_len_d     = cur_len_q;
    profile_d     = profile_q;
    compat_d      = compat_q;
    level_d       = level_q;
    nal_d         = nal_q;
    sps_total_d   = sps_total_q;
    pps_count_d   = pps_count_q;
    err_d         = err_q;
    finish        = 1'b0;
    idx           = 8'd0;
    len           = 16'd0;

    case (phase_q)
      RoleHeader: begin
        if (hpos_q == 3'd0) begin
          if (b != VersionOne) begin
            err_d   = StBadVer;
            phase_d = RoleError;
          end else begin
            hpos_d = 3'd1;
          end
        end else begin
          hpos_d = hpos_q + 3'd1;
          case (hpos_q)
            3'd1: profile_d = b;
            3'd2: compat_d  = b;
            3'd3: level_d   = b;
            3'd4: nal_d     = b[1:0];
            3'd5: begin
              sps_total_d   = b[4:0] & SpsMask;
              sets_left_d   = {3'd0, b[4:0]};
              set_counter_d = 8'd0;
              hpos_d        = 3'd0;
              phase_d       = (b[4:0] != 5'd0) ? RoleSpsLen : RolePpsCnt;
            end
            default: ;
          endcase
        end
      end
      RoleSpsLen, RolePpsLen: begin
        idx = set_counter_q;
        if (hpos_q == 3'd0) begin
          length_high_d = b;
          hpos_d        = 3'd1;
        end else begin
          len          = len_word;
          cur_len_d    = len_word;
          bytes_left_d = len_word;
          hpos_d       = 3'd0;
          if (len_word == 16'd0) begin
            finish = 1'b1;
          end else begin
            phase_d = is_sps ? RoleSpsData : RolePpsData;
          end
        end
      end
      RoleSpsData, RolePpsData: begin
        idx          = set_counter_q;
        len          = cur_len_q;
        bytes_left_d = bytes_left_q - 16'd1;
        finish       = (bytes_left_d == 16'd0);
      end
      RolePpsCnt: begin
        pps_count_d   = b;
        sets_left_d   = b;
        set_counter_d = 8'd0;
        hpos_d        = 3'd0;
        phase_d       = (b != 8'd0) ? RolePpsLen : RoleTrail;
      end
      default: ;
    endcase

    // End of a set: step to the next set of the list, or on to the next list.
    if (finish) begin
      sets_left_d   = sets_left_q - 8'd1;
      set_counter_d = set_counter_q + 8'd1;
      hpos_d        = 3'd0;
      cur_len_d     = 16'd0;
      if (sets_left_d != 8'd0) begin
        phase_d = is_sps ? RoleSpsLen : RolePpsLen;
      end else begin
        phase_d = is_sps ? RolePpsCnt : RoleTrail;
      end
    end

    if (err_d != StRunning) begin
      status = err_d;
    end else if (in_data_i.last_byte) begin
      status = (phase_d == RoleTrail) ? StOk : StTrunc;
    end else begin
      status = StRunning;
    end

    out_d.byte_role        = phase_q;
    out_d.status           = status;
    out_d.profile_code     = profile_d;
    out_d.compat_flags     = compat_d;
    out_d.level_code       = level_d;
    out_d.nal_length_bytes = {1'b0, nal_d} + 3'd1;
    out_d.sps_total        = sps_total_d;
    out_d.pps_total        = pps_count_d;
    out_d.set_index        = idx;
    out_d.set_length       = len;
    out_d.end_of_box       = in_data_i.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= RoleHeader;
      hpos_q        <= 3'd0;
      sets_left_q   <= 8'd0;
      set_counter_q <= 8'd0;
      bytes_left_q  <= 16'd0;
      length_high_q <= 8'd0;
      cur_len_q     <= 16'd0;
      profile_q     <= 8'd0;
      compat_q      <= 8'd0;
      level_q       <= 8'd0;
      nal_q         <= 2'd0;
      sps_total_q   <= 5'd0;
      pps_count_q   <= 8'd0;
      err_q         <= StRunning;
    end else if (in_acc) begin
      if (in_data_i.last_byte) begin
        // The box is complete, so the next byte opens a new one.
        phase_q       <= RoleHeader;
        hpos_q        <= 3'd0;
        sets_left_q   <= 8'd0;
        set_counter_q <= 8'd0;
        bytes_left_q  <= 16'd0;
        length_high_q <= 8'd0;
        cur_len_q     <= 16'd0;
        profile_q     <= 8'd0;
        compat_q      <= 8'd0;
        level_q       <= 8'd0;
        nal_q         <= 2'd0;
        sps_total_q   <= 5'd0;
        pps_count_q   <= 8'd0;
        err_q         <= StRunning;
      end else begin
        phase_q       <= phase_d;
        hpos_q        <= hpos_d;
        sets_left_q   <= sets_left_d;
        set_counter_q <= set_counter_d;
        bytes_left_q  <= bytes_left_d;
        length_high_q <= length_high_d;
        cur_len_q     <= cur_len_d;
        profile_q     <= profile_d;
        compat_q      <= compat_d;
        level_q       <= level_d;
        nal_q         <= nal_d;
        sps_total_q   <= sps_total_d;
        pps_count_q   <= pps_count_d;
        err_q         <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A final status is only ever reported on the last byte of a box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == StOk || out_data_o.status == StTrunc))
      |-> out_data_o.end_of_box)
    else $error("final status without end of box");

  // Bytes after a bad version always carry the bad version status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_role == RoleError) |-> (out_data_o.status == StBadVer))
    else $error("error role without bad version status");

  // The last byte of a box returns the parser to the start of a header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.last_byte)
      |=> (phase_q == RoleHeader && hpos_q == 3'd0 && err_q == StRunning))
    else $error("parser state not cleared after end of box");

  // A stalled result must not be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("pending result lost");

endmodule
